// ----- hdl/quaternion_report_to_euler_assert.svh -----
// Assertion macros shared by the checker.
`ifndef QUATERNION_REPORT_TO_EULER_ASSERT_SVH
`define QUATERNION_REPORT_TO_EULER_ASSERT_SVH

// Property checked outside reset.
`define QRTE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qrte assertion failed");

// Property checked at every edge, reset included.
`define QRTE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qrte assertion failed");

`endif

// ----- hdl/qrte_pkg.sv -----
`default_nettype none
package qrte_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  localparam int ACC_W = 34;  // product sums
  localparam int CW = 36;     // CORDIC x / y
  localparam int ZW = 30;     // angle accumulator, degrees * 2^20

  localparam logic [7:0] REPORT_ID_RST = 8'd5;
  localparam logic signed [ZW-1:0] DEG90_Q20 = 30'sd94371840;
  localparam logic signed [ZW-1:0] YAW_LIM = 30'sd23040;
  localparam logic signed [ZW-1:0] PITCH_LIM = 30'sd11520;
  localparam logic signed [ACC_W-1:0] Q28_ONE = 34'sd268435456;

  typedef struct packed {
    logic        cmp;    // compute new angles from quat
    logic        emit;   // give a result after any compute
    logic        fresh;  // refreshed flag of that result
    logic [63:0] quat;   // r, i, j, k from the low bits up
  } qrte_job_t;

  function automatic logic [26:0] atan_q20(input logic [4:0] idx);
    logic [26:0] v;
    case (idx)
      5'd0:  v = 27'd47185920;
      5'd1:  v = 27'd27855475;
      5'd2:  v = 27'd14718068;
      5'd3:  v = 27'd7471121;
      5'd4:  v = 27'd3750058;
      5'd5:  v = 27'd1876857;
      5'd6:  v = 27'd938658;
      5'd7:  v = 27'd469357;
      5'd8:  v = 27'd234682;
      5'd9:  v = 27'd117342;
      5'd10: v = 27'd58671;
      5'd11: v = 27'd29335;
      5'd12: v = 27'd14668;
      5'd13: v = 27'd7334;
      5'd14: v = 27'd3667;
      5'd15: v = 27'd1833;
      5'd16: v = 27'd917;
      5'd17: v = 27'd458;
      5'd18: v = 27'd229;
      5'd19: v = 27'd115;
      5'd20: v = 27'd57;
      5'd21: v = 27'd29;
      5'd22: v = 27'd14;
      5'd23: v = 27'd7;
      default: v = 27'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/qrte_front.sv -----
`default_nettype none
module qrte_front import qrte_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] report_id,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       queue_full,
  output logic            push,
  output qrte_job_t       job
);

  logic        seen_r, seen_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] quat_r, quat_nxt;
  logic        accept;
  logic        cmp;

  assign in_tready = !queue_full;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    seen_nxt = seen_r;
    cnt_nxt = cnt_r;
    quat_nxt = quat_r;
    cmp = 1'b0;
    if (!seen_r) begin
      if (in_tdata == report_id) begin
        seen_nxt = 1'b1;
        cnt_nxt = 4'd0;
      end
    end else if (cnt_r < 4'd8) begin
      quat_nxt[cnt_r[2:0]*8 +: 8] = in_tdata;
      cnt_nxt = cnt_r + 4'd1;
      cmp = (cnt_r == 4'd7);
    end
    job.cmp = cmp;
    job.emit = in_tlast;
    job.fresh = seen_nxt && (cnt_nxt == 4'd8);
    job.quat = quat_nxt;
    // end of buffer: close any open report
    if (in_tlast) begin
      seen_nxt = 1'b0;
      cnt_nxt = 4'd0;
    end
  end

  assign push = accept && (cmp || in_tlast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
      cnt_r <= 4'd0;
    end else if (accept) begin
      seen_r <= seen_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      quat_r <= quat_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/qrte_queue.sv -----
`default_nettype none
module qrte_queue import qrte_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  qrte_job_t      job_in,
  input  wire logic      pop,
  output qrte_job_t      job_out,
  output logic           job_valid,
  output logic           full
);

  qrte_job_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_pop;

  assign job_valid = (count_r != 2'd0);
  assign full = (count_r == 2'd2);
  assign job_out = mem_r[rd_ptr_r];
  assign do_pop = pop && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && do_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/qrte_back.sv -----
`default_nettype none
module qrte_back import qrte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  qrte_job_t        job_in,
  input  wire logic        job_valid,
  output logic             job_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,
  output logic             out_tuser
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_SAT   = 4'd2;
  localparam logic [3:0] ST_SQ    = 4'd3;
  localparam logic [3:0] ST_RINIT = 4'd4;
  localparam logic [3:0] ST_ROOT  = 4'd5;
  localparam logic [3:0] ST_CLD   = 4'd6;
  localparam logic [3:0] ST_CRUN  = 4'd7;
  localparam logic [3:0] ST_CEND  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  localparam logic [1:0] SEL_YAW   = 2'd0;
  localparam logic [1:0] SEL_ROLL  = 2'd1;
  localparam logic [1:0] SEL_PITCH = 2'd2;

  logic [3:0]  state_r;
  logic [4:0]  cnt_r;
  logic [63:0] q_r;
  logic        emit_r;
  logic        fresh_r;
  logic signed [31:0] prod_r;
  logic signed [ACC_W-1:0] acc_yx_r, acc_rx_r, acc_yy_r, acc_ry_r, acc_a_r;
  logic signed [29:0] a_r;
  logic [57:0] sq_r;
  logic [57:0] rad_r;
  logic [28:0] root_r;
  logic [31:0] rem_r;
  logic [1:0]  sel_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic        zero_r;
  logic signed [15:0] held_yaw_r, held_roll_r;
  logic signed [14:0] held_pitch_r;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_user_r;

  logic signed [15:0] op_a, op_b;
  logic signed [15:0] c_r, c_i, c_j, c_k;
  logic [4:0]  prev;
  logic signed [ACC_W-1:0] p_ext, a_dbl;
  logic signed [29:0] a_sat;
  logic [28:0] a_mag;
  logic [31:0] rem_sh, root_t;
  logic signed [CW-1:0] ld_x, ld_y, xs, ys;
  logic signed [ZW-1:0] z_rnd, ang, lim;
  logic        out_free;

  assign c_r = q_r[15:0];
  assign c_i = q_r[31:16];
  assign c_j = q_r[47:32];
  assign c_k = q_r[63:48];
  assign prev = cnt_r - 5'd1;
  assign p_ext = ACC_W'(prod_r);
  assign out_free = !out_valid_r || out_tready;
  assign job_pop = (state_r == ST_IDLE) && job_valid;

  // product sequence: squares first, then the cross terms
  always_comb begin
    case (cnt_r)
      5'd0:    begin op_a = c_r; op_b = c_r; end
      5'd1:    begin op_a = c_i; op_b = c_i; end
      5'd2:    begin op_a = c_j; op_b = c_j; end
      5'd3:    begin op_a = c_k; op_b = c_k; end
      5'd4:    begin op_a = c_i; op_b = c_j; end
      5'd5:    begin op_a = c_r; op_b = c_k; end
      5'd6:    begin op_a = c_r; op_b = c_i; end
      5'd7:    begin op_a = c_j; op_b = c_k; end
      5'd8:    begin op_a = c_r; op_b = c_j; end
      5'd9:    begin op_a = c_i; op_b = c_k; end
      default: begin op_a = c_r; op_b = c_r; end
    endcase
  end

  always_comb begin
    a_dbl = acc_a_r <<< 1;
    if (a_dbl > Q28_ONE) begin
      a_sat = 30'sd268435456;
    end else if (a_dbl < -Q28_ONE) begin
      a_sat = -30'sd268435456;
    end else begin
      a_sat = a_dbl[29:0];
    end
    a_mag = a_r[29] ? 29'(-a_r) : a_r[28:0];
  end

  assign rem_sh = {rem_r[29:0], rad_r[57:56]};
  assign root_t = {1'b0, root_r, 2'b01};

  always_comb begin
    case (sel_r)
      SEL_YAW: begin
        ld_y = CW'(acc_yy_r <<< 1);
        ld_x = CW'(acc_yx_r);
      end
      SEL_ROLL: begin
        ld_y = CW'(acc_ry_r <<< 1);
        ld_x = CW'(acc_rx_r);
      end
      default: begin
        ld_y = CW'(a_r);
        ld_x = CW'({1'b0, root_r});
      end
    endcase
  end

  assign xs = cx_r >>> cnt_r;
  assign ys = cy_r >>> cnt_r;

  always_comb begin
    z_rnd = (cz_r + ZW'(4096)) >>> 13;
    lim = (sel_r == SEL_PITCH) ? PITCH_LIM : YAW_LIM;
    if (zero_r) begin
      ang = '0;
    end else if (z_rnd > lim) begin
      ang = lim;
    end else if (z_rnd < -lim) begin
      ang = -lim;
    end else begin
      ang = z_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      held_yaw_r <= '0;
      held_pitch_r <= '0;
      held_roll_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken result unless ST_OUT reloads the register at this edge
      if (out_valid_r && out_tready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            if (job_in.cmp) begin
              state_r <= ST_MUL;
            end else begin
              state_r <= ST_OUT;
            end
          end
        end
        ST_MUL: begin
          if (cnt_r == 5'd10) begin
            state_r <= ST_SAT;
          end
        end
        ST_SAT:   state_r <= ST_SQ;
        ST_SQ:    state_r <= ST_RINIT;
        ST_RINIT: state_r <= ST_ROOT;
        ST_ROOT: begin
          if (cnt_r == 5'd28) begin
            state_r <= ST_CLD;
          end
        end
        ST_CLD: state_r <= ST_CRUN;
        ST_CRUN: begin
          if (cnt_r == 5'(CORDIC_N - 1)) begin
            state_r <= ST_CEND;
          end
        end
        ST_CEND: begin
          case (sel_r)
            SEL_YAW:  held_yaw_r <= ang[15:0];
            SEL_ROLL: held_roll_r <= ang[15:0];
            default:  held_pitch_r <= ang[14:0];
          endcase
          if (sel_r == SEL_PITCH) begin
            state_r <= emit_r ? ST_OUT : ST_IDLE;
          end else begin
            state_r <= ST_CLD;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        q_r <= job_in.quat;
        emit_r <= job_in.emit;
        fresh_r <= job_in.fresh;
        cnt_r <= '0;
        sel_r <= SEL_YAW;
        acc_yx_r <= '0;
        acc_rx_r <= '0;
        acc_yy_r <= '0;
        acc_ry_r <= '0;
        acc_a_r <= '0;
      end
      ST_MUL: begin
        if (cnt_r < 5'd10) begin
          prod_r <= op_a * op_b;
        end
        if (cnt_r != 5'd0) begin
          case (prev)
            5'd0: begin
              acc_yx_r <= acc_yx_r + p_ext;
              acc_rx_r <= acc_rx_r + p_ext;
            end
            5'd1: begin
              acc_yx_r <= acc_yx_r + p_ext;
              acc_rx_r <= acc_rx_r - p_ext;
            end
            5'd2: begin
              acc_yx_r <= acc_yx_r - p_ext;
              acc_rx_r <= acc_rx_r - p_ext;
            end
            5'd3: begin
              acc_yx_r <= acc_yx_r - p_ext;
              acc_rx_r <= acc_rx_r + p_ext;
            end
            5'd4, 5'd5: acc_yy_r <= acc_yy_r + p_ext;
            5'd6, 5'd7: acc_ry_r <= acc_ry_r + p_ext;
            5'd8: acc_a_r <= acc_a_r + p_ext;
            5'd9: acc_a_r <= acc_a_r - p_ext;
            default: acc_a_r <= acc_a_r;
          endcase
        end
        cnt_r <= cnt_r + 5'd1;
      end
      ST_SAT: a_r <= a_sat;
      ST_SQ:  sq_r <= 58'(a_mag * a_mag);
      ST_RINIT: begin
        rad_r <= (58'd1 << 56) - sq_r;
        root_r <= '0;
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_ROOT: begin
        if (rem_sh >= root_t) begin
          rem_r <= rem_sh - root_t;
          root_r <= {root_r[27:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          root_r <= {root_r[27:0], 1'b0};
        end
        rad_r <= rad_r << 2;
        cnt_r <= cnt_r + 5'd1;
      end
      ST_CLD: begin
        zero_r <= (ld_x == '0) && (ld_y == '0);
        cnt_r <= '0;
        if (ld_x < 0) begin
          if (ld_y >= 0) begin
            cx_r <= ld_y;
            cy_r <= -ld_x;
            cz_r <= DEG90_Q20;
          end else begin
            cx_r <= -ld_y;
            cy_r <= ld_x;
            cz_r <= -DEG90_Q20;
          end
        end else begin
          cx_r <= ld_x;
          cy_r <= ld_y;
          cz_r <= '0;
        end
      end
      ST_CRUN: begin
        if (cy_r > 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + ZW'(atan_q20(cnt_r));
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - ZW'(atan_q20(cnt_r));
        end
        cnt_r <= cnt_r + 5'd1;
      end
      ST_CEND: sel_r <= sel_r + 2'd1;
      ST_OUT: begin
        if (out_free) begin
          out_data_r <= {1'b0, held_roll_r, held_pitch_r, held_yaw_r};
          out_user_r <= fresh_r;
        end
      end
      default: cnt_r <= cnt_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule
`default_nettype wire

// ----- hdl/quaternion_report_to_euler.sv -----
// A last byte reaches out_tvalid via the job queue, ST_OUT and the output register
// when the back end is idle and no report completes in the buffer. Bytes are taken
// one per cycle while the angle unit works; the front stalls only when its
// two-entry job queue is full.
// Reset (rst_n low, synchronous): report_id returns to 5, held angles to zero,
// the queue and the open report are dropped and out_tvalid falls.
`default_nettype none
module quaternion_report_to_euler import qrte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: report_id
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // input bytes
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] yaw_angle, [30:16] pitch_angle,
                                       // [46:31] roll_angle, [47] zero
  output logic             out_tuser   // refreshed
);

  logic [7:0] report_id_r;
  logic       push;
  logic       pop;
  logic       job_valid;
  logic       queue_full;
  qrte_job_t  job_push;
  qrte_job_t  job_head;

  // hold the identifier byte; the user must write it only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      report_id_r <= REPORT_ID_RST;
    end else if (cfg_wr_en) begin
      report_id_r <= cfg_wr_data;
    end
  end

  // front: scan the buffer, gather the report, post one job per transaction
  // that completes a report or closes the buffer
  qrte_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .report_id  (report_id_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .queue_full (queue_full),
    .push       (push),
    .job        (job_push)
  );

  qrte_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .job_in    (job_push),
    .pop       (pop),
    .job_out   (job_head),
    .job_valid (job_valid),
    .full      (queue_full)
  );

  // back: products, asin argument root, three CORDIC passes, then the result if the job emits one
  qrte_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_in     (job_head),
    .job_valid  (job_valid),
    .job_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

// ----- hdl/qrte_checker.sv -----
`default_nettype none
`include "quaternion_report_to_euler_assert.svh"
module qrte_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  logic signed [15:0] yaw_w;
  logic signed [14:0] pitch_w;

  assign yaw_w = out_tdata[15:0];
  assign pitch_w = out_tdata[30:16];

  `QRTE_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid)
  `QRTE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `QRTE_ASSERT(a_yaw_rng, out_tvalid |-> (yaw_w <= 16'sd23040 && yaw_w >= -16'sd23040))
  `QRTE_ASSERT(a_pitch_rng, out_tvalid |-> (pitch_w <= 15'sd11520 && pitch_w >= -15'sd11520))

endmodule

bind quaternion_report_to_euler qrte_checker u_qrte_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
